[rtl/core/stream_side_classifier_assert.svh]
// assertion macros for the stream side classifier
`ifndef STREAM_SIDE_CLASSIFIER_ASSERT_SVH
`define STREAM_SIDE_CLASSIFIER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SSC_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("stream side classifier check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SSC_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("stream side classifier check failed");

`endif

[rtl/core/ssc_pkg.sv]
// shared types, constants and direction math for the stream side classifier
package ssc_pkg;

  localparam int unsigned NUM_NBR = 8;
  localparam int unsigned DIR_W   = 3;
  localparam int unsigned DIRS_W  = NUM_NBR * DIR_W;

  typedef logic [DIR_W-1:0]   dir_t;
  typedef logic [NUM_NBR-1:0] lane_mask_t;
  typedef logic signed [2:0]  cross_t;

  // half turn on the d8 compass
  localparam dir_t DIR_HALF_TURN = dir_t'(4);

  // x component of the unit step for a d8 code, north is +y
  function automatic cross_t step_x(input dir_t d);
    cross_t r;
    case (d)
      3'd0: r = 3'sd0;
      3'd1: r = 3'sd1;
      3'd2: r = 3'sd1;
      3'd3: r = 3'sd1;
      3'd4: r = 3'sd0;
      3'd5: r = -3'sd1;
      3'd6: r = -3'sd1;
      3'd7: r = -3'sd1;
      default: r = 3'sd0;
    endcase
    return r;
  endfunction

  // y component of the unit step for a d8 code
  function automatic cross_t step_y(input dir_t d);
    cross_t r;
    case (d)
      3'd0: r = 3'sd1;
      3'd1: r = 3'sd1;
      3'd2: r = 3'sd0;
      3'd3: r = -3'sd1;
      3'd4: r = -3'sd1;
      3'd5: r = -3'sd1;
      3'd6: r = 3'sd0;
      3'd7: r = 3'sd1;
      default: r = 3'sd0;
    endcase
    return r;
  endfunction

  // z of the cross product of two unit steps, range -2..2
  function automatic cross_t cross_z(input dir_t a, input dir_t b);
    cross_t p1;
    cross_t p2;
    p1 = step_x(a) * step_y(b);
    p2 = step_y(a) * step_x(b);
    return p1 - p2;
  endfunction

endpackage

[rtl/core/stream_side_classifier.sv]
// stream side classifier: three-stage pipeline from neighborhood to bank side
//
// Input channel (in_valid / in_ready) carries one request per stream cell hit
// by a flow line: flow direction, the stream cell's direction, and the valid
// mask and d8 codes of its eight neighbors. Output channel (out_valid /
// out_ready) returns one result per request: side_left, side_right, both set
// when the side is undetermined (opposite flow, channel head, junction).
// Each request passes through the input register, the lane stage that
// finds tributaries and their sides, and the reduction into the output
// register. Throughput is one request per cycle while out_ready is high;
// every stage holds its own valid bit and moves whenever the stage after
// it is empty or moving.
// When out_ready is low the output holds and the stages behind it fill; a
// request keeps being taken until all three stages are full, then in_ready
// drops. Nothing is lost or repeated across a stall.
// Reset (rst_n low, synchronous) clears all valid bits; the pipeline is
// empty and ready in the first cycle after reset.
`include "stream_side_classifier_assert.svh"

module stream_side_classifier
  import ssc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [DIR_W-1:0]   in_flow_dir,
  input  logic [DIR_W-1:0]   in_stream_dir,
  input  logic [NUM_NBR-1:0] in_neighbor_valid,
  input  logic [DIRS_W-1:0]  in_neighbor_dirs,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_side_left,
  output logic               out_side_right
);

  // stage enables, back to front
  logic en1;
  logic en2;
  logic en3;

  // stage 1: captured request
  logic                s1_v_r;
  dir_t                s1_fl_r;
  dir_t                s1_st_r;
  lane_mask_t          s1_nv_r;
  logic [DIRS_W-1:0]   s1_nd_r;

  // stage 2: per-lane tributary and side
  logic       s2_v_r;
  logic       s2_opp_r;
  lane_mask_t s2_trib_r;
  lane_mask_t s2_right_r;
  logic       s2_opp_nxt;
  lane_mask_t s2_trib_nxt;
  lane_mask_t s2_right_nxt;

  // stage 3: result register
  logic out_v_r;
  logic left_r;
  logic right_r;
  logic left_nxt;
  logic right_nxt;

  assign en3      = !out_v_r || out_ready;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || en2;
  assign in_ready = en1;

  // stage 1 valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= in_valid;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      s1_fl_r <= in_flow_dir;
      s1_st_r <= in_stream_dir;
      s1_nv_r <= in_neighbor_valid;
      s1_nd_r <= in_neighbor_dirs;
    end
  end

  // lane logic: a neighbor is a tributary when it points back at the cell
  always_comb begin
    cross_t za;
    cross_t zb;
    cross_t zc;
    dir_t   back_dir;
    logic   sign_clash;
    s2_opp_nxt   = (s1_fl_r == dir_t'(s1_st_r + DIR_HALF_TURN));
    za           = cross_z(s1_fl_r, s1_st_r);
    s2_trib_nxt  = '0;
    s2_right_nxt = '0;
    for (int i = 0; i < NUM_NBR; i++) begin
      back_dir        = dir_t'(i) + DIR_HALF_TURN;
      s2_trib_nxt[i]  = s1_nv_r[i] && (s1_nd_r[i*DIR_W +: DIR_W] == back_dir);
      zb              = cross_z(s1_fl_r, back_dir);
      zc              = cross_z(s1_st_r, back_dir);
      sign_clash      = ((za < 0) && (zb > 0)) || ((za > 0) && (zb < 0));
      if (!sign_clash && (zb != 0)) begin
        s2_right_nxt[i] = (zb < 0);
      end else begin
        s2_right_nxt[i] = (zc < 0);
      end
    end
  end

  // stage 2 valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en2) begin
      s2_v_r <= s1_v_r;
    end
  end

  // stage 2 payload
  always_ff @(posedge clk) begin
    if (en2 && s1_v_r) begin
      s2_opp_r   <= s2_opp_nxt;
      s2_trib_r  <= s2_trib_nxt;
      s2_right_r <= s2_right_nxt & s2_trib_nxt;
    end
  end

  // reduction: all tributaries must agree, otherwise undetermined; opposite flow or no tributary is also undetermined
  always_comb begin
    logic all_right;
    logic none_right;
    all_right  = (s2_right_r == s2_trib_r);
    none_right = (s2_right_r == '0);
    if (s2_opp_r || (s2_trib_r == '0) || !(all_right || none_right)) begin
      left_nxt  = 1'b1;
      right_nxt = 1'b1;
    end else begin
      left_nxt  = none_right;
      right_nxt = all_right;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en3) begin
      out_v_r <= s2_v_r;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (en3 && s2_v_r) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  assign out_valid      = out_v_r;
  assign out_side_left  = left_r;
  assign out_side_right = right_r;

  // checks
  `SSC_ASSERT_IMP(a_result_not_empty, out_v_r, left_r || right_r)
  `SSC_ASSERT_NEXT(a_opposite_undetermined, s2_v_r && en3 && s2_opp_r, left_r && right_r)
  `SSC_ASSERT_NEXT(a_head_undetermined, s2_v_r && en3 && (s2_trib_r == '0), left_r && right_r)
  `SSC_ASSERT_NEXT(a_s1_holds_on_stall, s1_v_r && !en2, s1_v_r && $stable(s1_fl_r))

endmodule
